>>> design/srtf_task_scheduler_defines.svh
// ----------------------------------------------------------------------------
// srtf_task_scheduler_defines
// Assertion macros used by the srtf_task_scheduler source.
// ----------------------------------------------------------------------------
`ifndef SRTF_TASK_SCHEDULER_DEFINES_SVH
`define SRTF_TASK_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
`define SRTF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("srtf assertion failed");
`define SRTF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("srtf assertion failed");
`else
`define SRTF_ASSERT(lbl, clk, rst_n, prop)
`define SRTF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> design/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// Types and constants of the shortest-remaining-time-first scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [2:0] ST_LOADED = 3'd0;
    localparam logic [2:0] ST_RAN    = 3'd1;
    localparam logic [2:0] ST_IDLE   = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_ZERO   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    typedef struct packed {
        logic        req_type;
        logic [15:0] task_id;
        logic [31:0] arrival_time;
        logic [31:0] burst_length;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] run_task_id;
        logic [31:0] start_time;
        logic [31:0] end_time;
        logic        task_finished;
    } t_out_item;

    // best candidate handed down the chain
    typedef struct packed {
        logic        found;
        logic [31:0] rem;
        logic [31:0] arr;
        logic [15:0] id;
    } t_cand;

    // per-cell control from the sequencer
    typedef struct packed {
        logic        load_en;
        logic        dec_en;
        logic [31:0] cur_time;
        logic [15:0] id;
        logic [31:0] arr;
        logic [31:0] burst;
    } t_cell_ctl;

endpackage

>>> design/srtf_cell.sv
// ----------------------------------------------------------------------------
// srtf_cell
// One task slot: holds its entry and merges it into the candidate beat
// coming from the previous cell.
// ----------------------------------------------------------------------------
module srtf_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srtf_pkg::t_cell_ctl i_ctl,
    input  srtf_pkg::t_cand     i_cand,
    input  logic [IDX_W-1:0]    i_idx,
    output srtf_pkg::t_cand     o_cand,
    output logic [IDX_W-1:0]    o_idx
);
    import srtf_pkg::*;

    logic        r_valid;
    logic [15:0] r_id;
    logic [31:0] r_arr;
    logic [31:0] r_rem;
    t_cand       r_cand;
    logic [IDX_W-1:0] r_idx;

    logic elig;
    logic take;

    always_comb begin
        elig = r_valid && (r_rem != 32'd0) && (r_arr <= i_ctl.cur_time);
        take = elig && (!i_cand.found || (r_rem < i_cand.rem) ||
                        ((r_rem == i_cand.rem) && (r_arr < i_cand.arr)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_cand.found <= 1'b0;
        end else begin
            if (i_ctl.load_en) begin
                r_valid <= 1'b1;
            end
            r_cand.found <= take || i_cand.found;
        end
        if (i_ctl.load_en) begin
            r_id  <= i_ctl.id;
            r_arr <= i_ctl.arr;
            r_rem <= i_ctl.burst;
        end else if (i_ctl.dec_en) begin
            r_rem <= r_rem - 32'd1;
        end
        if (take) begin
            r_cand.rem <= r_rem;
            r_cand.arr <= r_arr;
            r_cand.id  <= r_id;
            r_idx      <= IDX_W'(CELL_IDX);
        end else begin
            r_cand.rem <= i_cand.rem;
            r_cand.arr <= i_cand.arr;
            r_cand.id  <= i_cand.id;
            r_idx      <= i_idx;
        end
    end

    assign o_cand = r_cand;
    assign o_idx  = r_idx;

endmodule

>>> design/srtf_task_scheduler.sv
// Load beat and all-done tick: result registered one cycle after acceptance.
// Tick with loaded work: result registered after the sweep, once the result slot is
// free; the candidate beat walks the cell chain one cell per cycle in the sweep.
// One item in flight; next item accepted once the result slot is free.
// Synchronous active-low reset empties the table and clears time and counts.
// ----------------------------------------------------------------------------
// srtf_task_scheduler
// Preemptive SRTF scheduler with one-unit slices over a chain of task cells.
// ----------------------------------------------------------------------------
`include "srtf_task_scheduler_defines.svh"

module srtf_task_scheduler #(
    parameter int MAX_TASKS = srtf_pkg::MAX_TASKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  srtf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output srtf_pkg::t_out_item o_out_data
);
    import srtf_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_RESULT
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_cnt;
    logic [31:0]      r_time;
    logic [CNT_W-1:0] r_load_cnt;
    logic [CNT_W-1:0] r_fin_cnt;
    logic             r_out_valid;
    t_out_item        r_out;

    t_cand            w_cand [MAX_TASKS+1];
    logic [IDX_W-1:0] w_idx  [MAX_TASKS+1];

    logic             out_free;
    logic             in_fire;
    logic             full;
    logic             load_ok;
    logic             all_done;
    logic             run_go;
    logic             out_set;
    logic [31:0]      t_next;
    logic [IDX_W-1:0] slot;
    t_cand            best;
    logic [IDX_W-1:0] best_idx;

    always_comb begin
        out_free = !r_out_valid || i_out_ready;
        in_fire  = i_in_valid && o_in_ready;
        full     = (r_load_cnt == CNT_W'(MAX_TASKS));
        load_ok  = in_fire && (i_in_data.req_type == REQ_LOAD) && !full &&
                   (i_in_data.burst_length != 32'd0);
        all_done = (r_fin_cnt >= r_load_cnt);
        t_next   = (r_time == TIME_MAX) ? TIME_MAX : r_time + 32'd1;
        slot     = r_load_cnt[IDX_W-1:0];
        best     = w_cand[MAX_TASKS];
        best_idx = w_idx[MAX_TASKS];
        run_go   = (r_state == S_RESULT) && out_free;
        out_set  = (in_fire && ((i_in_data.req_type == REQ_LOAD) || all_done)) || run_go;
    end

    assign o_in_ready = (r_state == S_IDLE) && out_free;

    assign w_cand[0] = '0;
    assign w_idx[0]  = '0;

    for (genvar gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
        t_cell_ctl ctl;
        always_comb begin
            ctl.load_en  = load_ok && (slot == IDX_W'(gi));
            ctl.dec_en   = run_go && best.found && (best_idx == IDX_W'(gi));
            ctl.cur_time = r_time;
            ctl.id       = i_in_data.task_id;
            ctl.arr      = i_in_data.arrival_time;
            ctl.burst    = i_in_data.burst_length;
        end
        srtf_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_cand  (w_cand[gi]),
            .i_idx   (w_idx[gi]),
            .o_cand  (w_cand[gi+1]),
            .o_idx   (w_idx[gi+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_time      <= '0;
            r_load_cnt  <= '0;
            r_fin_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_set) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in_data.req_type == REQ_LOAD) begin
                            if (full) begin
                                r_out <= '{ST_FULL, 16'd0, 32'd0, 32'd0, 1'b0};
                            end else if (i_in_data.burst_length == 32'd0) begin
                                r_out <= '{ST_ZERO, 16'd0, 32'd0, 32'd0, 1'b0};
                            end else begin
                                r_out      <= '{ST_LOADED, 16'd0, 32'd0, 32'd0, 1'b0};
                                r_load_cnt <= r_load_cnt + CNT_W'(1);
                            end
                        end else if (all_done) begin
                            r_out <= '{ST_DONE, 16'd0, r_time, r_time, 1'b0};
                        end else begin
                            r_cnt   <= '0;
                            r_state <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP: begin
                    r_cnt <= r_cnt + IDX_W'(1);
                    if (r_cnt == IDX_W'(MAX_TASKS - 1)) begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_out.start_time <= r_time;
                        r_out.end_time   <= t_next;
                        r_time           <= t_next;
                        if (best.found) begin
                            r_out.status        <= ST_RAN;
                            r_out.run_task_id   <= best.id;
                            r_out.task_finished <= (best.rem == 32'd1);
                            if (best.rem == 32'd1) begin
                                r_fin_cnt <= r_fin_cnt + CNT_W'(1);
                            end
                        end else begin
                            r_out.status        <= ST_IDLE;
                            r_out.run_task_id   <= '0;
                            r_out.task_finished <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SRTF_ASSERT(a_fin_le_load, i_clk, i_rst_n, r_fin_cnt <= r_load_cnt)
    `SRTF_ASSERT(a_load_le_max, i_clk, i_rst_n, r_load_cnt <= CNT_W'(MAX_TASKS))
    `SRTF_ASSERT(a_time_stable_sweep, i_clk, i_rst_n,
                 (r_state == S_SWEEP) |=> $stable(r_time))
    `SRTF_ASSERT(a_result_kind, i_clk, i_rst_n,
                 run_go |=> (r_out_valid &&
                             ((r_out.status == ST_RAN) || (r_out.status == ST_IDLE))))
    `SRTF_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE))

endmodule

>>> tb/sv/srtf_schedule_checker.sv
// ----------------------------------------------------------------------------
// srtf_schedule_checker
// Watches the request and result channels of the SRTF scheduler. Each
// accepted request beat is run through a local model of the task table to
// give the expected result beat. Each accepted result beat is checked field by
// field against the oldest expected one.
// ----------------------------------------------------------------------------
module srtf_schedule_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  srtf_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  srtf_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import srtf_pkg::*;

    localparam int N_SLOTS = MAX_TASKS_DEF;

    logic [15:0] slot_id        [N_SLOTS];
    logic [31:0] slot_arrival   [N_SLOTS];
    logic [31:0] slot_remaining [N_SLOTS];
    logic [31:0] now_time;
    int          n_loaded;
    int          n_finished;
    t_out_item   expected_results [$];

    function automatic t_out_item schedule_beat(input t_in_item req);
        t_out_item   res;
        int          pick;
        logic [31:0] next_time;
        res = '0;
        if (req.req_type == REQ_LOAD) begin
            if (n_loaded >= N_SLOTS) begin
                res.status = ST_FULL;
            end else if (req.burst_length == '0) begin
                res.status = ST_ZERO;
            end else begin
                slot_id[n_loaded]        = req.task_id;
                slot_arrival[n_loaded]   = req.arrival_time;
                slot_remaining[n_loaded] = req.burst_length;
                n_loaded++;
                res.status = ST_LOADED;
            end
            return res;
        end
        if (n_finished >= n_loaded) begin
            res.status     = ST_DONE;
            res.start_time = now_time;
            res.end_time   = now_time;
            return res;
        end
        // least remaining, then earliest arrival, then lowest slot
        pick = -1;
        for (int k = 0; k < n_loaded; k++) begin
            if (slot_remaining[k] != '0 && slot_arrival[k] <= now_time) begin
                if (pick < 0 || slot_remaining[k] < slot_remaining[pick] ||
                    (slot_remaining[k] == slot_remaining[pick] &&
                     slot_arrival[k] < slot_arrival[pick])) begin
                    pick = k;
                end
            end
        end
        next_time      = (now_time == TIME_MAX) ? TIME_MAX : now_time + 32'd1;
        res.start_time = now_time;
        res.end_time   = next_time;
        now_time       = next_time;
        if (pick < 0) begin
            res.status = ST_IDLE;
            return res;
        end
        slot_remaining[pick] = slot_remaining[pick] - 32'd1;
        res.status      = ST_RAN;
        res.run_task_id = slot_id[pick];
        if (slot_remaining[pick] == '0) begin
            res.task_finished = 1'b1;
            n_finished++;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            now_time   = '0;
            n_loaded   = 0;
            n_finished = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with none expected, expected none, got 0x%0h",
                             $time, i_out_data);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(i_out_data.status));
                    check_field("run_task_id", 32'(want.run_task_id),
                                32'(i_out_data.run_task_id));
                    check_field("start_time", want.start_time, i_out_data.start_time);
                    check_field("end_time", want.end_time, i_out_data.end_time);
                    check_field("task_finished", 32'(want.task_finished),
                                32'(i_out_data.task_finished));
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.insert(expected_results.size(), schedule_beat(i_in_data));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> tb/sv/srtf_task_scheduler_tb.sv
// ----------------------------------------------------------------------------
// srtf_task_scheduler_tb
// Drives load and tick beats into the SRTF scheduler: a directed opening
// (empty table, zero burst, idle ticks, late loads, duplicate ids, ties,
// never-ready tasks) followed by random traffic that fills the table and runs
// it down. Both channels idle at random; the checker judges the results.
// ----------------------------------------------------------------------------
module srtf_task_scheduler_tb;
    import srtf_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;
    int        fail_count;
    int        pending;
    int        ticks_sent;
    int        send_calm;

    srtf_task_scheduler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    srtf_schedule_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_in_item load_beat(input logic [15:0] id, input logic [31:0] arr,
                                           input logic [31:0] burst);
        t_in_item b;
        b.req_type     = REQ_LOAD;
        b.task_id      = id;
        b.arrival_time = arr;
        b.burst_length = burst;
        return b;
    endfunction

    // payload of a tick is don't-care, so fill it with noise
    function automatic t_in_item tick_beat();
        t_in_item b;
        b.req_type     = REQ_TICK;
        b.task_id      = 16'($urandom);
        b.arrival_time = $urandom;
        b.burst_length = $urandom;
        return b;
    endfunction

    task automatic send_beat(input t_in_item beat);
        int gap;
        gap = 0;
        if (send_calm > 0) begin
            send_calm--;
        end else begin
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 31) == 0) send_calm = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (beat.req_type == REQ_TICK) ticks_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        int stall;
        int calm;
        calm = 0;
        i_out_ready <= 1'b0;
        forever begin
            stall = 0;
            if (calm > 0) begin
                calm--;
            end else begin
                stall = $urandom_range(0, 15);
                if ($urandom_range(0, 31) == 0) calm = $urandom_range(10, 40);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        t_in_item    beat;
        logic [31:0] arr;
        logic [31:0] burst_len;
        int          roll;
        send_calm  = 0;
        ticks_sent = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(tick_beat());                                   // empty table
        send_beat(load_beat(16'h0001, 32'h0, 32'h0));             // zero burst
        send_beat(load_beat(16'hFFFF, 32'd3, 32'd2));
        send_beat(tick_beat());                                   // idle
        send_beat(tick_beat());
        send_beat(load_beat(16'h0000, 32'd0, 32'd3));             // late load
        send_beat(load_beat(16'h0000, 32'd1, 32'd3));             // duplicate id
        send_beat(load_beat(16'h5A5A, 32'd0, 32'd3));             // full tie
        repeat (8) send_beat(tick_beat());
        send_beat(load_beat(16'h1234, TIME_MAX, TIME_MAX));       // never ready
        send_beat(load_beat(16'h8001, 32'h8000_0000, 32'h7FFF_FFFF));
        repeat (4) send_beat(tick_beat());
        drain_results();

        for (int n = 0; n < 1150; n++) begin
            if ($urandom_range(0, 5) == 0) begin
                roll = $urandom_range(0, 15);
                if (roll == 0) begin
                    burst_len = '0;
                end else if (roll == 1) begin
                    burst_len = $urandom;
                end else begin
                    burst_len = $urandom_range(1, 24);
                end
                if ($urandom_range(0, 7) == 0) begin
                    arr = $urandom;
                end else begin
                    arr = $urandom_range(0, ticks_sent + 16);
                end
                beat = load_beat(16'($urandom), arr, burst_len);
            end else begin
                beat = tick_beat();
            end
            send_beat(beat);
            if ($urandom_range(0, 99) == 0) drain_results();
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("srtf_task_scheduler_tb passed");
        end else begin
            $display("srtf_task_scheduler_tb failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("srtf_task_scheduler_tb failed");
        $finish;
    end

endmodule
